[sv/trc_pkg.sv]
// ----------------------------------------------------------------------------
// Text region console package
// Sizes, codes, types and helpers shared by the console sequencer and the
// top level.
// ----------------------------------------------------------------------------
package trc_pkg;

   // Cell store geometry. COLS_MAX is a power of two so a cell address is
   // simply {row, col}.
   localparam int COLS_MAX = 128;
   localparam int ROWS_MAX = 32;
   localparam int COL_W    = $clog2(COLS_MAX);
   localparam int ROW_W    = $clog2(ROWS_MAX);
   localparam int UCOL_W   = COL_W + 1;
   localparam int UROW_W   = ROW_W + 1;
   localparam int ADDR_W   = COL_W + ROW_W;
   localparam int DEPTH    = COLS_MAX * ROWS_MAX;

   localparam int CSR_DATA_W  = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int REP_W       = 3;

   localparam logic [7:0]  CH_LF      = 8'h0A;
   localparam logic [7:0]  CH_CR      = 8'h0D;
   localparam logic [7:0]  CH_BS      = 8'h08;
   localparam logic [7:0]  CH_TAB     = 8'h09;
   localparam logic [7:0]  CH_SPACE   = 8'h20;
   localparam logic [7:0]  ATTR_RESET = 8'h0F;
   localparam logic [15:0] BLANK_CELL = 16'h0020;
   localparam int          TAB_SPACES = 4;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } trc_op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ORIGIN_COL  = 3'd0,
      CSR_ORIGIN_ROW  = 3'd1,
      CSR_REGION_COLS = 3'd2,
      CSR_REGION_ROWS = 3'd3,
      CSR_TEXT_ATTR   = 3'd4,
      CSR_ENABLE      = 3'd5
   } trc_csr_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_PUT,
      ST_SCR_RD,
      ST_SCR_WR,
      ST_FILL,
      ST_DONE
   } trc_state_type;

   // Configuration as the sequencer sees it, with the region size saturated.
   typedef struct packed {
      logic [UCOL_W-1:0] used_cols;
      logic [UROW_W-1:0] used_rows;
      logic [7:0]        text_attr;
      logic              enable;
   } trc_cfg_type;

   typedef struct packed {
      logic [UCOL_W-1:0] cur_col;
      logic [ROW_W-1:0]  cur_row;
      logic [7:0]        cell_char;
      logic [7:0]        cell_attr;
      logic              scrolled;
      logic              ignored;
   } trc_res_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      cell_addr = {row, col};
   endfunction

endpackage

[sv/text_region_console_core.sv]
// A put goes from idle through the put state to the done state, and a wrap
// returns it to the put state for the write; a tab writes its spaces in turn. A read
// goes straight to the done state and a clear blanks the region in the fill state.
// A scroll copies each moved cell with a read and a write on the single port pair
// of the cell store, then blanks the last row. One item is in work at a time.
// Reset clears the cursor and registers, then a clearing pass blanks the store.
// ----------------------------------------------------------------------------
// Text region console core
// Top level: configuration registers, region size saturation and the result
// register in front of the response channel.
// ----------------------------------------------------------------------------
module text_region_console_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [trc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [trc_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_opcode,
   input  logic [7:0]                       req_char_code,
   input  logic [6:0]                       req_read_col,
   input  logic [4:0]                       req_read_row,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_cursor_screen_col,
   output logic [6:0]                       rsp_cursor_screen_row,
   output logic [7:0]                       rsp_cell_char,
   output logic [7:0]                       rsp_cell_attr,
   output logic                             rsp_scrolled,
   output logic                             rsp_ignored
);

   logic [6:0] origin_col_ff;
   logic [5:0] origin_row_ff;
   logic [7:0] region_cols_ff;
   logic [5:0] region_rows_ff;
   logic [7:0] text_attr_ff;
   logic       enable_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_col_ff;
   logic [6:0] rsp_row_ff;
   logic [7:0] rsp_char_ff;
   logic [7:0] rsp_attr_ff;
   logic       rsp_scrolled_ff;
   logic       rsp_ignored_ff;

   trc_pkg::trc_cfg_type cfg;
   trc_pkg::trc_res_type res;
   logic                 res_free;
   logic                 res_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_col_ff  <= '0;
         origin_row_ff  <= '0;
         region_cols_ff <= 8'd1;
         region_rows_ff <= 6'd1;
         text_attr_ff   <= trc_pkg::ATTR_RESET;
         enable_ff      <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            trc_pkg::CSR_ORIGIN_COL:  origin_col_ff  <= csr_write_data[6:0];
            trc_pkg::CSR_ORIGIN_ROW:  origin_row_ff  <= csr_write_data[5:0];
            trc_pkg::CSR_REGION_COLS: region_cols_ff <= csr_write_data[7:0];
            trc_pkg::CSR_REGION_ROWS: region_rows_ff <= csr_write_data[5:0];
            trc_pkg::CSR_TEXT_ATTR:   text_attr_ff   <= csr_write_data[7:0];
            trc_pkg::CSR_ENABLE:      enable_ff      <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // The region in use is clamped to at least one cell and at most the store.
   always_comb begin
      if (region_cols_ff == '0) begin
         cfg.used_cols = trc_pkg::UCOL_W'(1);
      end else if (trc_pkg::UCOL_W'(region_cols_ff) > trc_pkg::UCOL_W'(trc_pkg::COLS_MAX)) begin
         cfg.used_cols = trc_pkg::UCOL_W'(trc_pkg::COLS_MAX);
      end else begin
         cfg.used_cols = trc_pkg::UCOL_W'(region_cols_ff);
      end
      if (region_rows_ff == '0) begin
         cfg.used_rows = trc_pkg::UROW_W'(1);
      end else if (trc_pkg::UROW_W'(region_rows_ff) > trc_pkg::UROW_W'(trc_pkg::ROWS_MAX)) begin
         cfg.used_rows = trc_pkg::UROW_W'(trc_pkg::ROWS_MAX);
      end else begin
         cfg.used_rows = trc_pkg::UROW_W'(region_rows_ff);
      end
      cfg.text_attr = text_attr_ff;
      cfg.enable    = enable_ff;
   end

   trc_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_char_code (req_char_code),
      .req_read_col  (req_read_col),
      .req_read_row  (req_read_row),
      .res_free      (res_free),
      .res_done      (res_done),
      .res           (res)
   );

   // The result register frees up in the same cycle its transfer completes.
   assign res_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (res_done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_done) begin
         rsp_col_ff      <= 8'(trc_pkg::UCOL_W'(origin_col_ff) + res.cur_col);
         rsp_row_ff      <= 7'(7'(origin_row_ff) + 7'(res.cur_row));
         rsp_char_ff     <= res.cell_char;
         rsp_attr_ff     <= res.cell_attr;
         rsp_scrolled_ff <= res.scrolled;
         rsp_ignored_ff  <= res.ignored;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_cursor_screen_col = rsp_col_ff;
   assign rsp_cursor_screen_row = rsp_row_ff;
   assign rsp_cell_char         = rsp_char_ff;
   assign rsp_cell_attr         = rsp_attr_ff;
   assign rsp_scrolled          = rsp_scrolled_ff;
   assign rsp_ignored           = rsp_ignored_ff;

   a_init_stalls: assert property (@(posedge clock) $fell(reset) |-> req_stall)
      else $error("input taken during the clearing pass after reset");

   a_done_has_room: assert property (@(posedge clock) disable iff (reset)
      res_done |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result finished while the result register was occupied");

   a_ignored_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ignored) |->
         (!rsp_scrolled && rsp_cell_char == 8'h00 && rsp_cell_attr == 8'h00))
      else $error("ignored item reported a scroll or cell data");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      res_done |=> rsp_valid)
      else $error("finished result did not reach the response channel");

endmodule

[sv/trc_seq.sv]
// ----------------------------------------------------------------------------
// Text region console sequencer
// Owns the cell store and the cursor and walks each item through read,
// write, scroll and clear steps on a single synchronous memory.
// ----------------------------------------------------------------------------
module trc_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  trc_pkg::trc_cfg_type      cfg,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_opcode,
   input  logic [7:0]                req_char_code,
   input  logic [6:0]                req_read_col,
   input  logic [4:0]                req_read_row,
   input  logic                      res_free,
   output logic                      res_done,
   output trc_pkg::trc_res_type      res
);

   trc_pkg::trc_state_type state_ff, state_in;

   logic [trc_pkg::UCOL_W-1:0] col_ff, col_in;
   logic [trc_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [trc_pkg::ROW_W-1:0]  sr_ff, sr_in;
   logic [trc_pkg::COL_W-1:0]  sc_ff, sc_in;
   logic [trc_pkg::ADDR_W-1:0] init_ff, init_in;
   logic [7:0]                 ch_ff, ch_in;
   logic [trc_pkg::REP_W-1:0]  rep_ff, rep_in;
   logic                       scr_flag_ff, scr_flag_in;
   logic                       ign_ff, ign_in;
   logic                       hit_ff, hit_in;
   logic [15:0]                rd_data_ff;

   logic [15:0] mem [trc_pkg::DEPTH];

   logic                       mem_we;
   logic [trc_pkg::ADDR_W-1:0] mem_waddr;
   logic [15:0]                mem_wdata;
   logic                       mem_re;
   logic [trc_pkg::ADDR_W-1:0] mem_raddr;

   logic [trc_pkg::UCOL_W-1:0] cols_m1;
   logic [trc_pkg::UROW_W-1:0] rows_m1;
   logic [trc_pkg::ROW_W-1:0]  last_row;
   logic [trc_pkg::UROW_W-1:0] row_next;
   logic [trc_pkg::UROW_W-1:0] sr_next;
   logic                       sc_last;
   logic [trc_pkg::UCOL_W-1:0] col_m1;
   logic [7:0]                 put_char;

   assign cols_m1  = cfg.used_cols - trc_pkg::UCOL_W'(1);
   assign rows_m1  = cfg.used_rows - trc_pkg::UROW_W'(1);
   assign last_row = trc_pkg::ROW_W'(rows_m1);
   assign row_next = trc_pkg::UROW_W'(row_ff) + trc_pkg::UROW_W'(1);
   assign sr_next  = trc_pkg::UROW_W'(sr_ff) + trc_pkg::UROW_W'(1);
   assign sc_last  = (trc_pkg::UCOL_W'(sc_ff) == cols_m1);
   assign col_m1   = col_ff - trc_pkg::UCOL_W'(1);
   assign put_char = (ch_ff == trc_pkg::CH_TAB) ? trc_pkg::CH_SPACE : ch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= trc_pkg::ST_INIT;
         col_ff      <= '0;
         row_ff      <= '0;
         init_ff     <= '0;
         scr_flag_ff <= 1'b0;
         ign_ff      <= 1'b0;
         hit_ff      <= 1'b0;
         rep_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         init_ff     <= init_in;
         scr_flag_ff <= scr_flag_in;
         ign_ff      <= ign_in;
         hit_ff      <= hit_in;
         rep_ff      <= rep_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff <= sr_in;
      sc_ff <= sc_in;
      ch_ff <= ch_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      sr_in       = sr_ff;
      sc_in       = sc_ff;
      init_in     = init_ff;
      ch_in       = ch_ff;
      rep_in      = rep_ff;
      scr_flag_in = scr_flag_ff;
      ign_in      = ign_ff;
      hit_in      = hit_ff;
      mem_we      = 1'b0;
      mem_waddr   = trc_pkg::cell_addr(row_ff, trc_pkg::COL_W'(col_ff));
      mem_wdata   = trc_pkg::BLANK_CELL;
      mem_re      = 1'b0;
      mem_raddr   = trc_pkg::cell_addr(trc_pkg::ROW_W'(req_read_row),
                                       trc_pkg::COL_W'(req_read_col));
      req_stall   = 1'b1;
      res_done    = 1'b0;

      case (state_ff)
         trc_pkg::ST_INIT: begin
            // Clearing pass after reset: every cell becomes a blank.
            mem_we    = 1'b1;
            mem_waddr = init_ff;
            init_in   = init_ff + trc_pkg::ADDR_W'(1);
            if (init_ff == trc_pkg::ADDR_W'(trc_pkg::DEPTH - 1)) begin
               state_in = trc_pkg::ST_IDLE;
            end
         end

         trc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               mem_re      = 1'b1;
               scr_flag_in = 1'b0;
               ign_in      = !cfg.enable;
               hit_in      = cfg.enable
                             && (req_opcode == trc_pkg::OP_READ)
                             && (trc_pkg::UCOL_W'(req_read_col) < cfg.used_cols)
                             && (trc_pkg::UROW_W'(req_read_row) < cfg.used_rows);
               state_in    = trc_pkg::ST_DONE;
               if (cfg.enable) begin
                  case (req_opcode)
                     trc_pkg::OP_PUT: begin
                        // Pull a cursor left outside a shrunken region back in.
                        if (trc_pkg::UROW_W'(row_ff) >= cfg.used_rows) begin
                           row_in = last_row;
                        end
                        if (col_ff > cfg.used_cols) begin
                           col_in = cfg.used_cols;
                        end
                        ch_in    = req_char_code;
                        rep_in   = (req_char_code == trc_pkg::CH_TAB) ?
                                   trc_pkg::REP_W'(trc_pkg::TAB_SPACES) :
                                   trc_pkg::REP_W'(1);
                        state_in = trc_pkg::ST_PUT;
                     end
                     trc_pkg::OP_CLEAR: begin
                        col_in   = '0;
                        row_in   = '0;
                        sr_in    = '0;
                        sc_in    = '0;
                        rep_in   = '0;
                        state_in = trc_pkg::ST_FILL;
                     end
                     default: begin
                        state_in = trc_pkg::ST_DONE;
                     end
                  endcase
               end
            end
         end

         trc_pkg::ST_PUT: begin
            case (ch_ff)
               trc_pkg::CH_LF: begin
                  col_in   = '0;
                  state_in = trc_pkg::ST_DONE;
                  if (row_next >= cfg.used_rows) begin
                     row_in      = last_row;
                     scr_flag_in = 1'b1;
                     rep_in      = '0;
                     sr_in       = '0;
                     sc_in       = '0;
                     state_in    = (cfg.used_rows == trc_pkg::UROW_W'(1)) ?
                                   trc_pkg::ST_FILL : trc_pkg::ST_SCR_RD;
                  end else begin
                     row_in = trc_pkg::ROW_W'(row_next);
                  end
               end
               trc_pkg::CH_CR: begin
                  col_in   = '0;
                  state_in = trc_pkg::ST_DONE;
               end
               trc_pkg::CH_BS: begin
                  if (col_ff != '0) begin
                     col_in    = col_m1;
                     mem_we    = 1'b1;
                     mem_waddr = trc_pkg::cell_addr(row_ff, trc_pkg::COL_W'(col_m1));
                  end
                  state_in = trc_pkg::ST_DONE;
               end
               default: begin
                  if (col_ff >= cfg.used_cols) begin
                     // Wrap first; the write follows on a later visit.
                     col_in = '0;
                     if (row_next >= cfg.used_rows) begin
                        row_in      = last_row;
                        scr_flag_in = 1'b1;
                        sr_in       = '0;
                        sc_in       = '0;
                        state_in    = (cfg.used_rows == trc_pkg::UROW_W'(1)) ?
                                      trc_pkg::ST_FILL : trc_pkg::ST_SCR_RD;
                     end else begin
                        row_in = trc_pkg::ROW_W'(row_next);
                     end
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = {cfg.text_attr, put_char};
                     col_in    = col_ff + trc_pkg::UCOL_W'(1);
                     rep_in    = rep_ff - trc_pkg::REP_W'(1);
                     if (rep_ff == trc_pkg::REP_W'(1)) begin
                        state_in = trc_pkg::ST_DONE;
                     end
                  end
               end
            endcase
         end

         trc_pkg::ST_SCR_RD: begin
            mem_re    = 1'b1;
            mem_raddr = trc_pkg::cell_addr(trc_pkg::ROW_W'(sr_next), sc_ff);
            state_in  = trc_pkg::ST_SCR_WR;
         end

         trc_pkg::ST_SCR_WR: begin
            mem_we    = 1'b1;
            mem_waddr = trc_pkg::cell_addr(sr_ff, sc_ff);
            mem_wdata = rd_data_ff;
            state_in  = trc_pkg::ST_SCR_RD;
            if (sc_last) begin
               sc_in = '0;
               sr_in = trc_pkg::ROW_W'(sr_next);
               // Once the last row has been copied up, blank it.
               if (sr_next == rows_m1) begin
                  state_in = trc_pkg::ST_FILL;
               end
            end else begin
               sc_in = sc_ff + trc_pkg::COL_W'(1);
            end
         end

         trc_pkg::ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = trc_pkg::cell_addr(sr_ff, sc_ff);
            if (sc_last) begin
               sc_in = '0;
               if (trc_pkg::UROW_W'(sr_ff) == rows_m1) begin
                  // A put that scrolled still has characters to write.
                  state_in = (rep_ff != '0) ? trc_pkg::ST_PUT : trc_pkg::ST_DONE;
               end else begin
                  sr_in = trc_pkg::ROW_W'(sr_next);
               end
            end else begin
               sc_in = sc_ff + trc_pkg::COL_W'(1);
            end
         end

         trc_pkg::ST_DONE: begin
            res_done = res_free;
            if (res_free) begin
               state_in = trc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = trc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res.cur_col   = col_ff;
      res.cur_row   = row_ff;
      res.cell_char = hit_ff ? rd_data_ff[7:0] : 8'h00;
      res.cell_attr = hit_ff ? rd_data_ff[15:8] : 8'h00;
      res.scrolled  = scr_flag_ff;
      res.ignored   = ign_ff;
   end

endmodule

[tb/text_region_console_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text region console tracker
// Watches the register port and both channels of the console core. It keeps
// its own copy of the cell store, the cursor and the registers, works out the
// response for every request transfer and compares each response transfer,
// field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module text_region_console_tracker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [trc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [trc_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [1:0]                      req_opcode,
   input  logic [7:0]                      req_char_code,
   input  logic [6:0]                      req_read_col,
   input  logic [4:0]                      req_read_row,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [7:0]                      rsp_cursor_screen_col,
   input  logic [6:0]                      rsp_cursor_screen_row,
   input  logic [7:0]                      rsp_cell_char,
   input  logic [7:0]                      rsp_cell_attr,
   input  logic                            rsp_scrolled,
   input  logic                            rsp_ignored,
   output int                              fail_count,
   output int                              pending
);
   import trc_pkg::*;

   typedef struct packed {
      logic [7:0] screen_col;
      logic [6:0] screen_row;
      logic [7:0] glyph;
      logic [7:0] glyph_attr;
      logic       scrolled;
      logic       ignored;
   } console_view_type;

   logic [15:0]      cell_mirror [0:DEPTH-1];
   int               cursor_col;
   int               cursor_row;
   logic [6:0]       origin_col;
   logic [5:0]       origin_row;
   logic [7:0]       region_cols;
   logic [5:0]       region_rows;
   logic [7:0]       text_attr;
   logic             console_on;
   console_view_type owed_views [$];
   int               errors = 0;

   function automatic int cols_in_use();
      if (region_cols == 0) return 1;
      if (region_cols > COLS_MAX) return COLS_MAX;
      return int'(region_cols);
   endfunction

   function automatic int rows_in_use();
      if (region_rows == 0) return 1;
      if (region_rows > ROWS_MAX) return ROWS_MAX;
      return int'(region_rows);
   endfunction

   function automatic void scroll_up();
      int cols;
      int rows;
      int r;
      int c;
      cols = cols_in_use();
      rows = rows_in_use();
      for (r = 0; r + 1 < rows; r++) begin
         for (c = 0; c < cols; c++) begin
            cell_mirror[r * COLS_MAX + c] = cell_mirror[(r + 1) * COLS_MAX + c];
         end
      end
      for (c = 0; c < cols; c++) begin
         cell_mirror[(rows - 1) * COLS_MAX + c] = BLANK_CELL;
      end
   endfunction

   // Column zero of the next row; reports whether the region had to scroll.
   function automatic bit line_feed();
      cursor_col = 0;
      cursor_row++;
      if (cursor_row >= rows_in_use()) begin
         scroll_up();
         cursor_row = rows_in_use() - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit put_glyph(input logic [7:0] ch);
      bit wrapped;
      wrapped = 1'b0;
      if (cursor_col >= cols_in_use()) wrapped = line_feed();
      cell_mirror[cursor_row * COLS_MAX + cursor_col] = {text_attr, ch};
      cursor_col++;
      return wrapped;
   endfunction

   function automatic bit apply_put(input logic [7:0] ch);
      bit scrolled;
      int i;
      scrolled = 1'b0;
      // A region that shrank since the last put pulls the cursor back inside.
      if (cursor_row >= rows_in_use()) cursor_row = rows_in_use() - 1;
      if (cursor_col > cols_in_use()) cursor_col = cols_in_use();
      case (ch)
         CH_LF: scrolled = line_feed();
         CH_CR: cursor_col = 0;
         CH_BS: begin
            if (cursor_col > 0) begin
               cursor_col--;
               cell_mirror[cursor_row * COLS_MAX + cursor_col] = BLANK_CELL;
            end
         end
         CH_TAB: begin
            for (i = 0; i < TAB_SPACES; i++) begin
               if (put_glyph(CH_SPACE)) scrolled = 1'b1;
            end
         end
         default: scrolled = put_glyph(ch);
      endcase
      return scrolled;
   endfunction

   function automatic void blank_region();
      int r;
      int c;
      for (r = 0; r < rows_in_use(); r++) begin
         for (c = 0; c < cols_in_use(); c++) begin
            cell_mirror[r * COLS_MAX + c] = BLANK_CELL;
         end
      end
      cursor_col = 0;
      cursor_row = 0;
   endfunction

   function automatic console_view_type console_response(input trc_op_type op,
                                                         input logic [7:0] ch,
                                                         input logic [6:0] rc,
                                                         input logic [4:0] rr);
      console_view_type view;
      logic [15:0]      entry;
      view = '0;
      if (!console_on) begin
         view.ignored = 1'b1;
      end else begin
         case (op)
            OP_PUT: view.scrolled = apply_put(ch);
            OP_READ: begin
               if (int'(rc) < cols_in_use() && int'(rr) < rows_in_use()) begin
                  entry = cell_mirror[int'(rr) * COLS_MAX + int'(rc)];
                  view.glyph = entry[7:0];
                  view.glyph_attr = entry[15:8];
               end
            end
            OP_CLEAR: blank_region();
            default: ;
         endcase
      end
      view.screen_col = 8'((int'(origin_col) + cursor_col) & 8'hFF);
      view.screen_row = 7'((int'(origin_row) + cursor_row) & 7'h7F);
      return view;
   endfunction

   function automatic void check_field(input string label, input int want, input int seen);
      if (want != seen) begin
         errors++;
         $display("%0t: %s expected %0d, actual %0d", $time, label, want, seen);
      end
   endfunction

   always @(posedge clock) begin : watch
      console_view_type seen;
      console_view_type want;
      int i;
      if (reset) begin
         for (i = 0; i < DEPTH; i++) cell_mirror[i] = BLANK_CELL;
         cursor_col = 0;
         cursor_row = 0;
         origin_col = '0;
         origin_row = '0;
         region_cols = 8'd1;
         region_rows = 6'd1;
         text_attr = ATTR_RESET;
         console_on = 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (trc_csr_type'(csr_index))
               CSR_ORIGIN_COL:  origin_col = csr_write_data[6:0];
               CSR_ORIGIN_ROW:  origin_row = csr_write_data[5:0];
               CSR_REGION_COLS: region_cols = csr_write_data;
               CSR_REGION_ROWS: region_rows = csr_write_data[5:0];
               CSR_TEXT_ATTR:   text_attr = csr_write_data;
               CSR_ENABLE:      console_on = csr_write_data[0];
               default: ;
            endcase
         end
         // A response can never belong to a request taken at the same edge,
         // so responses are matched before the new request is queued.
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_cursor_screen_col, rsp_cursor_screen_row, rsp_cell_char,
                    rsp_cell_attr, rsp_scrolled, rsp_ignored};
            if (owed_views.size() == 0) begin
               errors++;
               $display("%0t: response transfer with none expected, actual %h",
                        $time, seen);
            end else begin
               want = owed_views.pop_front();
               check_field("cursor_screen_col", int'(want.screen_col),
                           int'(seen.screen_col));
               check_field("cursor_screen_row", int'(want.screen_row),
                           int'(seen.screen_row));
               check_field("cell_char", int'(want.glyph), int'(seen.glyph));
               check_field("cell_attr", int'(want.glyph_attr), int'(seen.glyph_attr));
               check_field("scrolled", int'(want.scrolled), int'(seen.scrolled));
               check_field("ignored", int'(want.ignored), int'(seen.ignored));
            end
         end
         if (req_valid && !req_stall) begin
            owed_views.push_back(console_response(trc_op_type'(req_opcode), req_char_code,
                                                  req_read_col, req_read_row));
         end
      end
      fail_count <= errors;
      pending <= owed_views.size();
   end

endmodule

[tb/text_region_console_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text region console core test
// Drives the console core through a directed sequence and a series of random
// window settings with random request and response idling, one long response
// hold-off, and a tracker that checks every response transfer.
// ----------------------------------------------------------------------------
module text_region_console_core_test;
   import trc_pkg::*;

   localparam int CYCLE_LIMIT   = 3000000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 100;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   logic                   req_valid;
   logic                   req_stall;
   logic [1:0]             req_opcode;
   logic [7:0]             req_char_code;
   logic [6:0]             req_read_col;
   logic [4:0]             req_read_row;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [7:0]             rsp_cursor_screen_col;
   logic [6:0]             rsp_cursor_screen_row;
   logic [7:0]             rsp_cell_char;
   logic [7:0]             rsp_cell_attr;
   logic                   rsp_scrolled;
   logic                   rsp_ignored;
   int                     fail_count;
   int                     pending;
   bit                     calm = 1'b0;
   bit                     hold_request = 1'b0;

   text_region_console_core dut (.*);

   text_region_console_tracker u_tracker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // Response side: short random stalls, plus one long hold-off on request.
   initial begin : rsp_side
      int n;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            for (n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_request = 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic offer(input trc_op_type op, input logic [7:0] ch,
                        input logic [6:0] rc, input logic [4:0] rr);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_char_code <= ch;
      req_read_col <= rc;
      req_read_row <= rr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic csr_put(input trc_csr_type idx, input logic [7:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   // Registers change only once every owed response has come back.
   task automatic program_window(input logic [7:0] org_c, input logic [7:0] org_r,
                                 input logic [7:0] cols, input logic [7:0] rows,
                                 input logic [7:0] attr, input logic enable_bit);
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_put(CSR_ORIGIN_COL, org_c);
      csr_put(CSR_ORIGIN_ROW, org_r);
      csr_put(CSR_REGION_COLS, cols);
      csr_put(CSR_REGION_ROWS, rows);
      csr_put(CSR_TEXT_ATTR, attr);
      csr_put(CSR_ENABLE, {7'd0, enable_bit});
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(input int count, input logic [7:0] org_c,
                            input logic [7:0] org_r, input logic [7:0] cols,
                            input logic [7:0] rows, input logic [7:0] attr,
                            input logic enable_bit);
      int         used_c;
      int         used_r;
      int         k;
      int         pick;
      trc_op_type op;
      logic [7:0] ch;
      logic [6:0] rc;
      logic [4:0] rr;
      program_window(org_c, org_r, cols, rows, attr, enable_bit);
      used_c = (cols == 0) ? 1 : (cols > COLS_MAX) ? COLS_MAX : int'(cols);
      used_r = (rows[5:0] == 0) ? 1 : (rows[5:0] > ROWS_MAX) ? ROWS_MAX : int'(rows[5:0]);
      for (k = 0; k < count; k++) begin
         if (k > 0 && !calm && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         pick = $urandom_range(0, 99);
         ch = 8'($urandom_range(0, 255));
         rc = 7'($urandom_range(0, 127));
         rr = 5'($urandom_range(0, 31));
         if (pick < 60) begin
            op = OP_PUT;
            case ($urandom_range(0, 9))
               0: ch = CH_LF;
               1: ch = CH_CR;
               2: ch = CH_BS;
               3: ch = CH_TAB;
               default: ;
            endcase
         end else if (pick < 87) begin
            op = OP_READ;
            // Most reads land inside the window, the rest anywhere.
            if (pick < 78) begin
               rc = 7'($urandom_range(0, used_c - 1));
               rr = 5'($urandom_range(0, used_r - 1));
            end
         end else if (pick < 94) begin
            op = OP_CLEAR;
         end else begin
            op = OP_NONE;
         end
         offer(op, ch, rc, rr);
      end
      req_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int p;
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_ORIGIN_COL;
      csr_write_data <= '0;
      req_valid <= 1'b0;
      req_opcode <= OP_PUT;
      req_char_code <= '0;
      req_read_col <= '0;
      req_read_row <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Still disabled out of reset: the item is ignored.
      offer(OP_READ, 8'h00, 7'd0, 5'd0);
      req_valid <= 1'b0;

      // Four by two window at the far corner of the screen.
      program_window(8'd127, 8'd63, 8'd4, 8'd2, 8'hFF, 1'b1);
      offer(OP_PUT, 8'h41, 7'd0, 5'd0);
      offer(OP_PUT, 8'hFF, 7'd0, 5'd0);
      offer(OP_PUT, 8'h00, 7'd0, 5'd0);
      offer(OP_PUT, 8'h42, 7'd0, 5'd0);
      offer(OP_READ, 8'h00, 7'd3, 5'd0);
      offer(OP_PUT, 8'h43, 7'd0, 5'd0);
      offer(OP_PUT, CH_LF, 7'd0, 5'd0);
      offer(OP_READ, 8'h00, 7'd0, 5'd0);
      offer(OP_PUT, 8'h44, 7'd0, 5'd0);
      offer(OP_PUT, CH_BS, 7'd0, 5'd0);
      offer(OP_PUT, CH_BS, 7'd0, 5'd0);
      offer(OP_PUT, CH_CR, 7'd0, 5'd0);
      offer(OP_PUT, CH_TAB, 7'd0, 5'd0);
      offer(OP_PUT, CH_TAB, 7'd0, 5'd0);
      offer(OP_READ, 8'h00, 7'd127, 5'd31);
      offer(OP_READ, 8'h00, 7'd4, 5'd0);
      offer(OP_NONE, 8'hFF, 7'd127, 5'd31);
      offer(OP_CLEAR, 8'h00, 7'd0, 5'd0);
      offer(OP_READ, 8'h00, 7'd0, 5'd0);
      req_valid <= 1'b0;

      // Window sizes of zero and beyond the store saturate inside the block.
      run_phase(50, 8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 1'b1);
      run_phase(50, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd255, 8'd1,
                8'($urandom_range(0, 255)), 1'b1);
      run_phase(40, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd3, 8'd63,
                8'($urandom_range(0, 255)), 1'b1);
      run_phase(15, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(1, 16)), 8'($urandom_range(1, 8)),
                8'($urandom_range(0, 255)), 1'b0);
      run_phase(30, 8'd127, 8'd63, 8'd128, 8'd32, 8'hFF, 1'b1);
      for (p = 0; p < 10; p++) begin
         if (p == 0) hold_request = 1'b1;
         if (p == 9) calm = 1'b1;
         run_phase(46, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(1, 16)), 8'($urandom_range(1, 8)),
                   8'($urandom_range(0, 255)), 1'b1);
      end

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/trc_pkg.sv
sv/trc_seq.sv
sv/text_region_console_core.sv
tb/text_region_console_tracker.sv
tb/text_region_console_core_test.sv
